[design/skt_pkg.sv]
package skt_pkg;

  localparam int NumEntriesDef = 5;
  localparam int KeyW          = 32;
  localparam int TotalW        = 31;

  localparam logic [TotalW-1:0] TotalMax = '1;

  // result kind codes
  localparam logic KindNotice = 1'b0;
  localparam logic KindReport = 1'b1;

  typedef struct packed {
    logic signed [KeyW-1:0] key_value;
    logic signed [KeyW-1:0] amount;
  } in_word_t;

  typedef struct packed {
    logic                   kind;
    logic signed [KeyW-1:0] entry_key;
    logic [TotalW-1:0]      entry_total;
    logic                   last;
  } out_word_t;

  // word as it sits in the queue, tagged by the front
  typedef struct packed {
    in_word_t word;
    logic     key_nonpos;
    logic     amt_nonpos;
  } q_word_t;

  typedef enum logic [2:0] {
    BsIdle,
    BsSortLoad,
    BsSortScan,
    BsSwapA,
    BsSwapB,
    BsMatch,
    BsNotice,
    BsReport
  } back_state_e;

endpackage

[design/skt_front.sv]
module skt_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  skt_pkg::in_word_t in_word_i,
  output logic              q_valid_o,
  input  logic              q_ready_i,
  output skt_pkg::q_word_t  q_word_o
);
  import skt_pkg::*;

  // two-entry queue
  q_word_t     buf_q [2];
  logic        wr_ptr_q;
  logic        rd_ptr_q;
  logic [1:0]  count_q;
  logic        push;
  logic        pop;
  q_word_t     cls_word;

  always_comb begin
    cls_word.word       = in_word_i;
    cls_word.key_nonpos = in_word_i.key_value[KeyW-1] || (in_word_i.key_value == '0);
    cls_word.amt_nonpos = in_word_i.amount[KeyW-1] || (in_word_i.amount == '0);
  end

  assign in_ready_o = (count_q != 2'd2);
  assign q_valid_o  = (count_q != 2'd0);
  assign q_word_o   = buf_q[rd_ptr_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_valid_o && q_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= cls_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push, pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

[design/skt_back.sv]
module skt_back #(
  parameter int NUM_ENTRIES = skt_pkg::NumEntriesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  output logic               q_ready_o,
  input  skt_pkg::q_word_t   q_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output skt_pkg::out_word_t out_word_o
);
  import skt_pkg::*;

  localparam int IdxW = $clog2(NUM_ENTRIES);
  localparam int CntW = $clog2(NUM_ENTRIES + 1);
  localparam logic [IdxW-1:0] LastIdx  = IdxW'(NUM_ENTRIES - 1);
  localparam logic [IdxW-1:0] SortLast = IdxW'(NUM_ENTRIES - 2);
  localparam logic [CntW-1:0] FullCnt  = CntW'(NUM_ENTRIES);
  localparam logic [CntW-1:0] LastCnt  = CntW'(NUM_ENTRIES - 1);

  back_state_e state_q, state_d;

  logic signed [KeyW-1:0] keys_q   [NUM_ENTRIES];
  logic [TotalW-1:0]      totals_q [NUM_ENTRIES];
  logic [CntW-1:0]        loaded_q;
  logic [IdxW-1:0]        i_q, j_q, min_idx_q;
  logic signed [KeyW-1:0] min_val_q, ival_q;
  q_word_t                item_q;
  logic                   out_valid_q;
  out_word_t              out_q;

  logic                   loaded_full;
  logic                   pop;
  logic                   out_free;
  logic [IdxW-1:0]        rd_idx;
  logic signed [KeyW-1:0] rd_key;
  logic [TotalW-1:0]      rd_total;
  logic                   key_hit;
  logic [TotalW:0]        sum;
  logic [TotalW-1:0]      sat_total;

  logic                   key_we;
  logic [IdxW-1:0]        key_waddr;
  logic signed [KeyW-1:0] key_wdata;
  logic                   tot_we;
  logic                   tot_clear;
  logic                   out_load;
  out_word_t              out_d;

  assign loaded_full = (loaded_q == FullCnt);
  assign q_ready_o   = (state_q == BsIdle);
  assign pop         = q_valid_i && q_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  // single read port on each table
  assign rd_idx   = (state_q == BsSortLoad) ? i_q : j_q;
  assign rd_key   = keys_q[rd_idx];
  assign rd_total = totals_q[rd_idx];
  assign key_hit  = (rd_key == item_q.word.key_value);

  // amount is known positive here, so its low bits carry its value
  assign sum       = {1'b0, rd_total} + {1'b0, item_q.word.amount[TotalW-1:0]};
  assign sat_total = sum[TotalW] ? TotalMax : sum[TotalW-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BsIdle: begin
        if (q_valid_i) begin
          if (!loaded_full) begin
            if (loaded_q == LastCnt) state_d = BsSortLoad;
          end else if (q_word_i.key_nonpos) begin
            state_d = BsReport;
          end else begin
            state_d = BsMatch;
          end
        end
      end
      BsSortLoad: state_d = BsSortScan;
      BsSortScan: begin
        if (j_q == LastIdx) state_d = BsSwapA;
      end
      BsSwapA: state_d = BsSwapB;
      BsSwapB: state_d = (i_q == SortLast) ? BsIdle : BsSortLoad;
      BsMatch: begin
        if (key_hit) begin
          state_d = item_q.amt_nonpos ? BsReport : BsIdle;
        end else if (j_q == LastIdx) begin
          state_d = BsNotice;
        end
      end
      BsNotice: begin
        if (out_free) state_d = BsIdle;
      end
      BsReport: begin
        if (out_free && (j_q == LastIdx)) state_d = BsIdle;
      end
      default: state_d = BsIdle;
    endcase
  end

  // state outputs
  always_comb begin
    key_we    = 1'b0;
    key_waddr = i_q;
    key_wdata = min_val_q;
    tot_we    = 1'b0;
    tot_clear = 1'b0;
    out_load  = 1'b0;
    out_d     = out_q;
    unique case (state_q)
      BsIdle: begin
        if (pop && !loaded_full) begin
          key_we    = 1'b1;
          key_waddr = loaded_q[IdxW-1:0];
          key_wdata = q_word_i.word.key_value;
        end
      end
      BsSwapA: begin
        key_we    = 1'b1;
        key_waddr = min_idx_q;
        key_wdata = ival_q;
      end
      BsSwapB: begin
        key_we = 1'b1;
      end
      BsMatch: begin
        tot_we = key_hit && !item_q.amt_nonpos;
      end
      BsNotice: begin
        out_load          = out_free;
        out_d.kind        = KindNotice;
        out_d.entry_key   = item_q.word.key_value;
        out_d.entry_total = '0;
        out_d.last        = 1'b1;
      end
      BsReport: begin
        out_load          = out_free;
        out_d.kind        = KindReport;
        out_d.entry_key   = rd_key;
        out_d.entry_total = rd_total;
        out_d.last        = (j_q == LastIdx);
        tot_clear         = out_free && (j_q == LastIdx);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      keys_q[key_waddr] <= key_wdata;
    end
    if (out_load) begin
      out_q <= out_d;
    end
    case (state_q)
      BsIdle: begin
        if (pop) item_q <= q_word_i;
      end
      BsSortLoad: begin
        min_val_q <= rd_key;
        ival_q    <= rd_key;
        min_idx_q <= i_q;
      end
      BsSortScan: begin
        if (rd_key < min_val_q) begin
          min_val_q <= rd_key;
          min_idx_q <= j_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BsIdle;
      loaded_q    <= '0;
      i_q         <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
      for (int e = 0; e < NUM_ENTRIES; e++) begin
        totals_q[e] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (tot_we) begin
        totals_q[j_q] <= sat_total;
      end
      if (tot_clear) begin
        for (int e = 0; e < NUM_ENTRIES; e++) begin
          totals_q[e] <= '0;
        end
        loaded_q <= '0;
      end else if (pop && !loaded_full) begin
        loaded_q <= loaded_q + CntW'(1);
      end
      case (state_q)
        BsIdle: begin
          i_q <= '0;
          j_q <= '0;
        end
        BsSortLoad: j_q <= i_q + IdxW'(1);
        BsSortScan: begin
          if (j_q != LastIdx) j_q <= j_q + IdxW'(1);
        end
        BsSwapB: i_q <= i_q + IdxW'(1);
        BsMatch: begin
          // a hit may lead into a report run, which starts at entry zero
          if (key_hit) j_q <= '0;
          else if (j_q != LastIdx) j_q <= j_q + IdxW'(1);
        end
        BsReport: begin
          if (out_free && (j_q != LastIdx)) j_q <= j_q + IdxW'(1);
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

[design/sorted_key_tally_table.sv]
// sorted key tally table
// input channel (in_valid_i / in_ready_o / in_word_i): one word carries a key and an amount.
// the first NUM_ENTRIES words of a round load keys; after the last load the table is
// selection sorted in place, one compare per cycle, for a table of N entries. later
// words credit a key, end the round, or get an unknown-key notice.
// output channel (out_valid_o / out_ready_i / out_word_o): notices and report words.
// a load word is written into the key table straight from idle; a credit or notice walks
// the sorted table one entry a cycle; a round end emits N report words, one per cycle
// while the receiver takes them. these per-entry walks over the single table read
// port set the rate: the back end takes no new word until a walk or sort ends.
// a two-entry queue in the front keeps taking words while the back end is busy; when it
// is full in_ready_o drops. a stalled receiver holds the output register and stalls the
// back end's next notice or report word until it is taken, which then backs up the queue.
// reset clears the load count, all totals and both valid flags; keys stay unknown until
// loaded.
module sorted_key_tally_table #(
  parameter int NUM_ENTRIES = skt_pkg::NumEntriesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  skt_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output skt_pkg::out_word_t out_word_o
);
  import skt_pkg::*;

  // queue between front and back
  logic    q_valid;
  logic    q_ready;
  q_word_t q_word;

  // front: classify the word by sign and queue it
  skt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .q_valid_o  (q_valid),
    .q_ready_i  (q_ready),
    .q_word_o   (q_word)
  );

  // back: key table, sorter, matcher and report sequencer
  skt_back #(
    .NUM_ENTRIES (NUM_ENTRIES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_word_i    (q_word),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

  // a notice is a single word with no total
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_word_o.kind == KindNotice)) |->
      (out_word_o.last && (out_word_o.entry_total == '0)))
    else $error("notice word malformed");

  // only positive keys can be rejected
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_word_o.kind == KindNotice)) |->
      (!out_word_o.entry_key[KeyW-1] && (out_word_o.entry_key != '0)))
    else $error("notice for a non-positive key");

  // front stalls only with words waiting in the queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> q_valid)
    else $error("front stalled with empty queue");

endmodule

[test/sorted_key_tally_table_tb.sv]
`timescale 1ns / 100ps

module sorted_key_tally_table_tb;
  import skt_pkg::*;

  localparam int NumEntries = NumEntriesDef;
  // sort pass plus one report run, with margin
  localparam int SettleCycles = 60;

  // clock and reset
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always #6 clk_i = ~clk_i;

  // block ports, inputs all known from time zero
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_word_t  in_word_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_word_t out_word_o;

  sorted_key_tally_table #(
    .NUM_ENTRIES(NumEntries)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o)
  );

  // idling knobs, in percent per cycle
  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  // receiver hold-off, counted down in the receiver process
  int hold_left = 0;

  // shadow copy of the table
  logic signed [KeyW-1:0] tally_keys [NumEntries];
  logic [TotalW-1:0]      tally_sums [NumEntries];
  int                     keys_loaded = 0;

  // words the block owes us, oldest first
  out_word_t pending_words[$];
  out_word_t oldest_word;

  int errors         = 0;
  int words_sent     = 0;
  int notices_seen   = 0;
  int reports_seen   = 0;
  int rounds_closed  = 0;
  int saturations    = 0;

  // ---------------------------------------------------------------------------
  // shadow table model
  // ---------------------------------------------------------------------------

  // index of the first entry holding key k, or -1
  function automatic int find_key(logic signed [KeyW-1:0] k);
    for (int i = 0; i < NumEntries; i++) begin
      if (tally_keys[i] == k) return i;
    end
    return -1;
  endfunction

  // selection sort, ascending signed, swap only when the minimum moved
  task automatic sort_tally_keys();
    int lo;
    logic signed [KeyW-1:0] tmp;
    for (int i = 0; i < NumEntries - 1; i++) begin
      lo = i;
      for (int j = i + 1; j < NumEntries; j++) begin
        if (tally_keys[j] < tally_keys[lo]) lo = j;
      end
      if (lo != i) begin
        tmp            = tally_keys[i];
        tally_keys[i]  = tally_keys[lo];
        tally_keys[lo] = tmp;
      end
    end
  endtask

  // report run: every entry in sorted order, then a fresh round
  task automatic close_round();
    out_word_t w;
    for (int i = 0; i < NumEntries; i++) begin
      w.kind        = KindReport;
      w.entry_key   = tally_keys[i];
      w.entry_total = tally_sums[i];
      w.last        = (i == NumEntries - 1);
      pending_words.push_back(w);
      tally_sums[i] = '0;
    end
    keys_loaded = 0;
  endtask

  // advance the shadow table by one accepted word
  task automatic apply_tally_word(in_word_t w);
    logic signed [KeyW-1:0] k;
    logic signed [KeyW-1:0] amt;
    logic [TotalW:0]        sum;
    out_word_t              note;
    int                     hit;
    k   = w.key_value;
    amt = w.amount;
    if (keys_loaded < NumEntries) begin
      tally_keys[keys_loaded] = k;
      keys_loaded++;
      if (keys_loaded == NumEntries) sort_tally_keys();
    end else if (k <= 0) begin
      close_round();
    end else begin
      hit = find_key(k);
      if (hit < 0) begin
        // unknown key: notice only, amount dropped
        note.kind        = KindNotice;
        note.entry_key   = k;
        note.entry_total = '0;
        note.last        = 1'b1;
        pending_words.push_back(note);
      end else if (amt <= 0) begin
        close_round();
      end else begin
        sum = {1'b0, tally_sums[hit]} + {1'b0, amt[TotalW-1:0]};
        if (sum > {1'b0, TotalMax}) begin
          tally_sums[hit] = TotalMax;
          saturations++;
        end else begin
          tally_sums[hit] = sum[TotalW-1:0];
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // driving and checking
  // ---------------------------------------------------------------------------

  // offer one word after a random gap, hold it until taken
  task automatic send_word(logic signed [KeyW-1:0] k, logic signed [KeyW-1:0] amt);
    in_word_t w;
    w.key_value = k;
    w.amount    = amt;
    @(negedge clk_i);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i = 1'b0;
      in_word_i  = {$urandom, $urandom};
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_word_i  = w;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
    apply_tally_word(w);
  endtask

  // stop offering, then wait until every owed word has come
  task automatic wait_all_results();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
  endtask

  // receiver: long hold-off first, else random stalls
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_ready_i = 1'b0;
      hold_left   = hold_left - 1;
    end else begin
      out_ready_i = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic check_field(string name, logic [KeyW-1:0] want, logic [KeyW-1:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t mismatch on %s: expected %h, got %h", $time, name, want, got);
    end
  endtask

  // every word taken is held against the oldest owed word
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_words.size() == 0) begin
        errors++;
        $display("%0t unexpected word: expected none, got %h", $time, out_word_o);
      end else begin
        oldest_word = pending_words.pop_front();
        check_field("kind", 32'(oldest_word.kind), 32'(out_word_o.kind));
        check_field("entry_key", oldest_word.entry_key, out_word_o.entry_key);
        check_field("entry_total", 32'(oldest_word.entry_total), 32'(out_word_o.entry_total));
        check_field("last", 32'(oldest_word.last), 32'(out_word_o.last));
        if (oldest_word.kind == KindNotice) notices_seen++;
        else reports_seen++;
        if (oldest_word.kind == KindReport && oldest_word.last) rounds_closed++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  // extremes, duplicates, saturation, notices and every way to close a round
  task automatic test_directed_cases();
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    // round with extreme keys, a negative key and a duplicate
    send_word(32'sh7fff_ffff, 32'sd0);
    send_word(32'sh8000_0000, 32'sh8000_0000);
    send_word(32'sd5, -32'sd1);
    send_word(32'sd5, 32'sh7fff_ffff);
    send_word(-32'sd1, 32'sd9);
    // only the first of the duplicate 5s gets credit, then it saturates
    send_word(32'sd5, 32'sh7fff_ffff);
    send_word(32'sd5, 32'sd1);
    send_word(32'sh7fff_ffff, 32'sd3);
    // unknown keys: notice, amount ignored even when negative
    send_word(32'sd6, 32'sd7);
    send_word(32'sh4000_0000, 32'sh8000_0000);
    // known key with zero amount closes the round
    send_word(32'sd5, 32'sd0);
    // round closed by key zero
    send_word(32'sd3, 32'sd1);
    send_word(32'sd1, 32'sd1);
    send_word(32'sd2, 32'sd1);
    send_word(32'sd0, 32'sd1);
    send_word(-32'sd7, 32'sd1);
    send_word(32'sd0, 32'sd44);
    // reversed loads, credit, then known key with negative amount
    send_word(32'sd9, 32'sd0);
    send_word(32'sd8, 32'sd0);
    send_word(32'sd7, 32'sd0);
    send_word(32'sd6, 32'sd0);
    send_word(32'sd5, 32'sd0);
    send_word(32'sd7, 32'sd100);
    send_word(32'sd9, -32'sd1);
    // round closed by the most negative key
    repeat (NumEntries) send_word(32'sd4, 32'sd2);
    send_word(32'sd4, 32'sd2);
    send_word(32'sh8000_0000, 32'sd5);
  endtask

  // random but well formed rounds: loads, then mostly credits, some notices,
  // then one of the ways to close
  task automatic test_random_traffic(int idle_pct, int stall_pct, int n_words);
    logic signed [KeyW-1:0] k;
    logic signed [KeyW-1:0] amt;
    int creditable[$];
    int pick;
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
    repeat (n_words) begin
      pick = $urandom_range(99);
      amt  = $urandom;
      if (keys_loaded < NumEntries) begin
        if (pick < 55) k = $urandom_range(12, 1);
        else if (pick < 75) k = $urandom;
        else if (pick < 88) k = (pick[0]) ? 32'sd0 : ($urandom | 32'h8000_0000);
        else if (pick < 94) k = 32'sh7fff_ffff;
        else k = 32'sh8000_0000;
      end else begin
        creditable.delete();
        for (int i = 0; i < NumEntries; i++) begin
          if (tally_keys[i] > 0) creditable.push_back(i);
        end
        if (pick < 72 && creditable.size() != 0) begin
          k = tally_keys[creditable[$urandom_range(creditable.size() - 1)]];
          if (pick < 50) amt = $urandom_range(1000, 1);
          else if (pick < 62) amt = $urandom_range(32'h7fff_ffff, 32'h4000_0000);
          else if (pick < 66) amt = $urandom & 32'h7fff_ffff;
          else if (pick < 69) amt = 32'sd0;
          else amt = $urandom | 32'h8000_0000;
        end else if (pick < 86) begin
          // unknown positive key
          do k = $urandom & 32'h7fff_ffff; while (k == 0 || find_key(k) >= 0);
        end else begin
          // key zero or less closes the round
          k = (pick < 90) ? 32'sd0 : ($urandom | 32'h8000_0000);
        end
      end
      send_word(k, amt);
    end
  endtask

  // receiver holds off while rounds keep coming: output register and queue
  // fill, the input stalls; then the sender waits for a full drain
  task automatic test_output_hold();
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    hold_left       = 120;
    repeat (3) begin
      repeat (NumEntries) send_word($urandom_range(20, 1), 32'sd0);
      send_word(-32'sd3, 32'sd0);
    end
    wait_all_results();
    repeat (SettleCycles) @(posedge clk_i);
    repeat (NumEntries) send_word(32'sd11, 32'sd0);
    send_word(32'sd11, 32'sd8);
    send_word(32'sd12, 32'sd8);
    send_word(32'sd0, 32'sd0);
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    for (int i = 0; i < NumEntries; i++) begin
      tally_keys[i] = '0;
      tally_sums[i] = '0;
    end
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_cases();
    test_random_traffic(0, 0, 70);
    test_random_traffic(84, 0, 70);
    test_random_traffic(0, 84, 70);
    test_random_traffic(36, 36, 70);
    test_output_hold();

    wait_all_results();
    repeat (SettleCycles) @(posedge clk_i);

    $display("sent %0d words; checked %0d report words over %0d rounds and %0d notices",
             words_sent, reports_seen, rounds_closed, notices_seen);
    $display("%0d saturating credits, idle and stall mixes up to 84%%, one long output hold",
             saturations);
    if (errors == 0 && pending_words.size() == 0) begin
      $display("sorted_key_tally_table_tb: PASS");
    end else begin
      $display("sorted_key_tally_table_tb: FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("sorted_key_tally_table_tb: FAIL");
    $finish;
  end

endmodule
